// File: rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the homography pixel scatter
// fixed-point widths, the register index map and the cell word type
// ----------------------------------------------------------------------------
`default_nettype none

package hps_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned PosW    = 9;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  // affine numerators reach about 2^42, perspective numerators 2^54
  localparam int unsigned NumW    = 44;
  localparam int unsigned DenW    = 44;
  localparam int unsigned DivW    = 58;   // numerator shifted up by 12 bits
  localparam int unsigned QuotW   = 58;
  localparam int unsigned DivSteps = 58;
  localparam int unsigned PerCell = 2;    // quotient bits resolved per cell
  localparam int unsigned NumCells = DivSteps / PerCell;

  localparam logic [CoefW-1:0] PerspOne = 32'h1000_0000;
  // 1.0 in Q16.16, also the affine divisor
  localparam logic [CoefW-1:0] CoefOne  = 32'h0001_0000;

  typedef enum logic [RegIdxW-1:0] {
    REG_ROW_GAIN_ROW = 3'd0,
    REG_ROW_GAIN_COL = 3'd1,
    REG_ROW_OFFSET   = 3'd2,
    REG_COL_GAIN_ROW = 3'd3,
    REG_COL_GAIN_COL = 3'd4,
    REG_COL_OFFSET   = 3'd5,
    REG_PERSP_ROW    = 3'd6,
    REG_PERSP_COL    = 3'd7
  } reg_idx_e;

  // one divider lane: magnitudes, partial remainder, quotient bits
  typedef struct packed {
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  num;
    logic [QuotW-1:0] quo;
    logic             neg;
  } lane_t;

  // word traveling down the chain of cells
  typedef struct packed {
    logic               vld;
    lane_t              row;
    lane_t              col;
    logic [DenW-1:0]    den;
    logic               ok;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
  } cell_word_t;

endpackage

`default_nettype wire

// File: rtl/hps_front.sv
// ----------------------------------------------------------------------------
// hps_front: matrix products and numerator / divisor formation
// two registered stages: products, then sums and magnitudes for the divider
// ----------------------------------------------------------------------------
`default_nettype none

module hps_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        vld_i,
  input  wire logic [hps_pkg::PosW-1:0]    row_i,
  input  wire logic [hps_pkg::PosW-1:0]    col_i,
  input  wire logic [hps_pkg::ChanW-1:0]   red_i,
  input  wire logic [hps_pkg::ChanW-1:0]   green_i,
  input  wire logic [hps_pkg::ChanW-1:0]   blue_i,
  input  wire logic                        persp_i,
  input  wire logic [hps_pkg::CoefW-1:0]   coef_i [hps_pkg::NumRegs],
  output hps_pkg::cell_word_t              word_o
);

  localparam int unsigned PW = hps_pkg::CoefW + hps_pkg::PosW + 1;

  logic                       s1_vld_q, s1_persp_q;
  logic signed [PW-1:0]       p_q [6];
  logic signed [hps_pkg::CoefW-1:0] off_r_q, off_c_q;
  logic [hps_pkg::ChanW-1:0]  s1_r_q, s1_g_q, s1_b_q;
  logic signed [PW-1:0]       p_d [6];
  hps_pkg::cell_word_t        word_d, word_q;
  logic                       vld_q;

  logic signed [hps_pkg::DenW-1:0] nr, nc, dd;
  logic [hps_pkg::DivW-1:0] anr, anc;
  logic [hps_pkg::DenW-1:0] add;

  always_comb begin
    p_d[0] = $signed(coef_i[hps_pkg::REG_ROW_GAIN_ROW]) * $signed({1'b0, row_i});
    p_d[1] = $signed(coef_i[hps_pkg::REG_ROW_GAIN_COL]) * $signed({1'b0, col_i});
    p_d[2] = $signed(coef_i[hps_pkg::REG_COL_GAIN_ROW]) * $signed({1'b0, row_i});
    p_d[3] = $signed(coef_i[hps_pkg::REG_COL_GAIN_COL]) * $signed({1'b0, col_i});
    p_d[4] = $signed(coef_i[hps_pkg::REG_PERSP_ROW]) * $signed({1'b0, row_i});
    p_d[5] = $signed(coef_i[hps_pkg::REG_PERSP_COL]) * $signed({1'b0, col_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q        <= p_d;
      off_r_q    <= $signed(coef_i[hps_pkg::REG_ROW_OFFSET]);
      off_c_q    <= $signed(coef_i[hps_pkg::REG_COL_OFFSET]);
      s1_persp_q <= persp_i;
      s1_r_q     <= red_i;
      s1_g_q     <= green_i;
      s1_b_q     <= blue_i;
    end
  end

  always_comb begin
    nr = hps_pkg::DenW'(p_q[0]) + hps_pkg::DenW'(p_q[1]) + hps_pkg::DenW'(off_r_q);
    nc = hps_pkg::DenW'(p_q[2]) + hps_pkg::DenW'(p_q[3]) + hps_pkg::DenW'(off_c_q);
    if (s1_persp_q) begin
      dd = hps_pkg::DenW'(p_q[4]) + hps_pkg::DenW'(p_q[5])
         + hps_pkg::DenW'(hps_pkg::PerspOne);
    end else begin
      dd = hps_pkg::DenW'(hps_pkg::CoefOne);
    end
    anr = hps_pkg::DivW'(nr[hps_pkg::DenW-1] ? -nr : nr);
    anc = hps_pkg::DivW'(nc[hps_pkg::DenW-1] ? -nc : nc);
    add = dd[hps_pkg::DenW-1] ? -dd : dd;
    word_d           = '0;
    word_d.vld       = s1_vld_q;
    // perspective: numerator scaled by 2^12 before the divide
    word_d.row.num   = s1_persp_q ? (anr << 12) : anr;
    word_d.col.num   = s1_persp_q ? (anc << 12) : anc;
    word_d.row.neg   = nr[hps_pkg::DenW-1] ^ dd[hps_pkg::DenW-1];
    word_d.col.neg   = nc[hps_pkg::DenW-1] ^ dd[hps_pkg::DenW-1];
    word_d.den       = add;
    word_d.ok        = (dd != '0);
    word_d.red       = s1_r_q;
    word_d.green     = s1_g_q;
    word_d.blue      = s1_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= word_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  // valid bit comes from the reset flop
  always_comb begin
    word_o     = word_q;
    word_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// File: rtl/hps_cell.sv
// ----------------------------------------------------------------------------
// hps_cell: one divider cell of the chain
// resolves two restoring-division quotient bits for both lanes, then registers
// ----------------------------------------------------------------------------
`default_nettype none

module hps_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire hps_pkg::cell_word_t word_i,
  output hps_pkg::cell_word_t      word_o
);

  hps_pkg::cell_word_t word_d, word_q;
  logic                vld_q;

  function automatic hps_pkg::lane_t div_step(hps_pkg::lane_t l,
                                              logic [hps_pkg::DenW-1:0] den);
    logic [hps_pkg::DivW:0] trial;
    hps_pkg::lane_t         r;
    r     = l;
    trial = {r.rem, r.num[hps_pkg::DivW-1]};
    r.num = {r.num[hps_pkg::DivW-2:0], 1'b0};
    if (trial >= {(hps_pkg::DivW-hps_pkg::DenW+1)'(0), den}) begin
      trial = trial - {(hps_pkg::DivW-hps_pkg::DenW+1)'(0), den};
      r.quo = {r.quo[hps_pkg::QuotW-2:0], 1'b1};
    end else begin
      r.quo = {r.quo[hps_pkg::QuotW-2:0], 1'b0};
    end
    r.rem = trial[hps_pkg::DivW-1:0];
    return r;
  endfunction

  always_comb begin
    word_d = word_i;
    for (int k = 0; k < hps_pkg::PerCell; k++) begin
      word_d.row = div_step(word_d.row, word_i.den);
      word_d.col = div_step(word_d.col, word_i.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= word_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  always_comb begin
    word_o     = word_q;
    word_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// File: rtl/homography_pixel_scatter.sv
// ----------------------------------------------------------------------------
// homography_pixel_scatter: forward projective mapping of one source pixel
// maps (row, col) through a 3x3 matrix, divides in a chain of divider cells,
// and flags the destination word for writing when it lands inside the frame
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  input    | in        | in_valid_i/in_stall_o    | src_row, src_col, rgb, mode
//  output   | out       | out_valid_o/out_stall_i  | dest_row, dest_col, rgb, write_enable
//  config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one word per clock while the output is not stalled; the path holds one product stage,
// one sum stage, 29 divider cells at two quotient bits each, one result stage
// the chain advances as a whole whenever the result register is free or taken
// reset clears all valid bits and loads the identity matrix
// stall on the output freezes the whole chain, the input stall follows it
//
`default_nettype none

module homography_pixel_scatter #(
  parameter int unsigned IMAGE_ROWS = 512,
  parameter int unsigned IMAGE_COLS = 512
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [hps_pkg::PosW-1:0]      src_row_i,
  input  wire logic [hps_pkg::PosW-1:0]      src_col_i,
  input  wire logic [hps_pkg::ChanW-1:0]     red_in_i,
  input  wire logic [hps_pkg::ChanW-1:0]     green_in_i,
  input  wire logic [hps_pkg::ChanW-1:0]     blue_in_i,
  input  wire logic                          mode_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [hps_pkg::PosW-1:0]           dest_row_o,
  output logic [hps_pkg::PosW-1:0]           dest_col_o,
  output logic [hps_pkg::ChanW-1:0]          red_out_o,
  output logic [hps_pkg::ChanW-1:0]          green_out_o,
  output logic [hps_pkg::ChanW-1:0]          blue_out_o,
  output logic                               write_enable_o,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [hps_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  wire logic [hps_pkg::CoefW-1:0]     cfg_data_i
);

  localparam int unsigned NC = hps_pkg::NumCells;

  logic [hps_pkg::CoefW-1:0] coef_q [hps_pkg::NumRegs];
  hps_pkg::cell_word_t       chain [NC+1];
  logic                      adv;
  logic                      out_valid_q;
  logic [hps_pkg::PosW-1:0]  dest_row_q, dest_col_q;
  logic [hps_pkg::ChanW-1:0] red_q, green_q, blue_q;
  logic                      we_q;

  // whole chain moves when the result register can take a word
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // coefficient registers, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hps_pkg::NumRegs; k++) begin
        coef_q[k] <= (k == int'(hps_pkg::REG_ROW_GAIN_ROW) ||
                      k == int'(hps_pkg::REG_COL_GAIN_COL)) ? hps_pkg::CoefOne : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  hps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (in_valid_i),
    .row_i   (src_row_i),
    .col_i   (src_col_i),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .persp_i (mode_i),
    .coef_i  (coef_q),
    .word_o  (chain[0])
  );

  // divider cells, each resolving two quotient bits per lane
  for (genvar g = 0; g < NC; g++) begin : g_cell
    hps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  // sign restore, truncation toward zero falls out of magnitude division
  hps_pkg::cell_word_t last;
  logic signed [hps_pkg::QuotW:0] qr, qc;
  logic in_frame;

  always_comb begin
    last = chain[NC];
    qr = last.row.neg ? -$signed({1'b0, last.row.quo}) : $signed({1'b0, last.row.quo});
    qc = last.col.neg ? -$signed({1'b0, last.col.quo}) : $signed({1'b0, last.col.quo});
    in_frame = !qr[hps_pkg::QuotW] && !qc[hps_pkg::QuotW]
            && (qr < $signed((hps_pkg::QuotW+1)'(IMAGE_ROWS)))
            && (qc < $signed((hps_pkg::QuotW+1)'(IMAGE_COLS)))
            && last.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      we_q       <= in_frame;
      dest_row_q <= in_frame ? qr[hps_pkg::PosW-1:0] : '0;
      dest_col_q <= in_frame ? qc[hps_pkg::PosW-1:0] : '0;
      red_q      <= last.red;
      green_q    <= last.green;
      blue_q     <= last.blue;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_row_o     = dest_row_q;
  assign dest_col_o     = dest_col_q;
  assign red_out_o      = red_q;
  assign green_out_o    = green_q;
  assign blue_out_o     = blue_q;
  assign write_enable_o = we_q;

`ifndef SYNTHESIS
  // input stall only when a result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a word held on a stalled output stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(dest_row_o)
      && $stable(dest_col_o) && $stable(write_enable_o)))
    else $error("stalled result changed");

  // a disabled write always carries a zero address
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (dest_row_o == '0 && dest_col_o == '0))
    else $error("nonzero address on disabled write");
`endif

endmodule

`default_nettype wire
